### hw/rtl/sbas_pkg.sv
// ============================================================================
// sbas_pkg - signed BCD add/subtract shared definitions
// Digit count, operation codes, item structs and the BCD digit clamp.
// ============================================================================
package sbas_pkg;

    localparam int DIGITS = 16;            // 2 .. 16
    localparam int DIG_W  = 4 * DIGITS;    // bits of the live digit field
    localparam int BUS_W  = 64;            // packed digit field on the ports

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_SUB = 1'b1;

    // +6 in every live nibble, the usual decimal-adjust bias
    localparam logic [DIG_W-1:0] SIX = {DIGITS{4'h6}};

    typedef struct packed {
        logic             op;
        logic [BUS_W-1:0] a_digits;
        logic             a_negative;
        logic [BUS_W-1:0] b_digits;
        logic             b_negative;
    } t_in;

    typedef struct packed {
        logic [BUS_W-1:0] sum_digits;
        logic             sum_negative;
        logic             overflow;
        logic             a_less_b;
        logic             a_equal_b;
    } t_out;

    // Keep the live nibbles, a non-decimal nibble reads as 9
    function automatic logic [DIG_W-1:0] bcd_norm(logic [BUS_W-1:0] v);
        logic [DIG_W-1:0] r;
        logic [3:0]       d;
        r = '0;
        for (int i = 0; i < DIGITS; i++) begin
            d = v[4*i +: 4];
            r[4*i +: 4] = (d > 4'd9) ? 4'd9 : d;
        end
        return r;
    endfunction

endpackage

### hw/rtl/signed_bcd_add_subtract.sv
// ============================================================================
// signed_bcd_add_subtract - sign-magnitude BCD adder/subtractor
// Four-stage pipeline: clamp, compare/order, binary add, decimal adjust.
// ============================================================================
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------
//  operation | start in, busy out     | i_in     (t_in)
//  result    | o_done out, no back-pr | o_result (t_out)
//
//  One item per cycle; each item passes the clamp, compare, add and adjust
//  registers in order to its result. The 64-bit decimal add is split over an
//  add stage and an adjust stage behind the compare stage.
//  Synchronous active-low reset empties the pipeline; busy is high in reset.
//  The result side never stalls, so busy is low at all other times.
// ============================================================================
module signed_bcd_add_subtract
    import sbas_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_in,
    output logic o_done,
    output t_out o_result
);

    // valid bits
    logic r_v1, r_v2, r_v3, r_v4;

    // stage 1: clamped magnitudes, signs with zero forced positive
    logic [DIG_W-1:0] r_s1_ma, r_s1_mb, n_s1_ma, n_s1_mb;
    logic             r_s1_na, r_s1_nb, r_s1_op;

    // stage 2: ordered, biased operands
    logic [DIG_W-1:0] r_s2_xa, r_s2_yb, n_s2_xa, n_s2_yb;
    logic             r_s2_sub, r_s2_neg, r_s2_less, r_s2_eq;
    logic             n_s2_sub, n_s2_neg, n_s2_less, n_s2_eq;

    // stage 3: raw binary sum and nibble carries
    logic [DIG_W-1:0]  r_s3_sum;
    logic [DIGITS-1:0] r_s3_cy, n_s3_cy;
    logic              r_s3_ovf, r_s3_neg, r_s3_less, r_s3_eq;
    logic [DIG_W:0]    n_s3_sum, n_s3_cv;

    // stage 4: output
    t_out             r_s4_out;
    logic [DIG_W-1:0] n_s4_mag;

    logic             accept;
    logic             nb_eff, a_gt, a_eq;
    logic [DIG_W-1:0] x, y;

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    // ---- stage 1 ----
    assign n_s1_ma = bcd_norm(i_in.a_digits);
    assign n_s1_mb = bcd_norm(i_in.b_digits);

    // ---- stage 2 ----
    always_comb begin
        nb_eff   = r_s1_nb ^ (r_s1_op == OP_SUB);
        n_s2_sub = r_s1_na ^ nb_eff;
        a_gt     = r_s1_ma > r_s1_mb;
        a_eq     = r_s1_ma == r_s1_mb;
        x        = a_gt ? r_s1_ma : r_s1_mb;
        y        = a_gt ? r_s1_mb : r_s1_ma;
        // add: x + 6 per nibble (no cross-nibble carry, digits <= 9) plus y
        // sub: x + ~y + 1
        n_s2_xa  = n_s2_sub ? x : (x + SIX);
        n_s2_yb  = n_s2_sub ? ~y : y;
        n_s2_neg = (!n_s2_sub || a_gt) ? r_s1_na : nb_eff;
        n_s2_eq  = (r_s1_na == r_s1_nb) && a_eq;
        if (r_s1_na != r_s1_nb) begin
            n_s2_less = r_s1_na;
        end else if (r_s1_na) begin
            n_s2_less = a_gt;
        end else begin
            n_s2_less = !a_gt && !a_eq;
        end
    end

    // ---- stage 3 ----
    always_comb begin
        n_s3_sum = {1'b0, r_s2_xa} + {1'b0, r_s2_yb} + {{DIG_W{1'b0}}, r_s2_sub};
        n_s3_cv  = n_s3_sum ^ {1'b0, r_s2_xa} ^ {1'b0, r_s2_yb};
        for (int i = 0; i < DIGITS; i++) begin
            n_s3_cy[i] = n_s3_cv[4*i+4];
        end
    end

    // ---- stage 4: a nibble without carry out (or with borrow) drops 6 ----
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            n_s4_mag[4*i +: 4] = r_s3_cy[i] ? r_s3_sum[4*i +: 4]
                                            : r_s3_sum[4*i +: 4] - 4'd6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_ma   <= n_s1_ma;
        r_s1_mb   <= n_s1_mb;
        r_s1_na   <= i_in.a_negative & (|n_s1_ma);
        r_s1_nb   <= i_in.b_negative & (|n_s1_mb);
        r_s1_op   <= i_in.op;

        r_s2_xa   <= n_s2_xa;
        r_s2_yb   <= n_s2_yb;
        r_s2_sub  <= n_s2_sub;
        r_s2_neg  <= n_s2_neg;
        r_s2_less <= n_s2_less;
        r_s2_eq   <= n_s2_eq;

        r_s3_sum  <= n_s3_sum[DIG_W-1:0];
        r_s3_cy   <= n_s3_cy;
        r_s3_ovf  <= !r_s2_sub && n_s3_sum[DIG_W];
        r_s3_neg  <= r_s2_neg;
        r_s3_less <= r_s2_less;
        r_s3_eq   <= r_s2_eq;

        r_s4_out.sum_digits   <= BUS_W'(n_s4_mag);
        r_s4_out.sum_negative <= r_s3_neg && (|n_s4_mag);
        r_s4_out.overflow     <= r_s3_ovf;
        r_s4_out.a_less_b     <= r_s3_less;
        r_s4_out.a_equal_b    <= r_s3_eq;
    end

    assign o_done   = r_v4;
    assign o_result = r_s4_out;

endmodule

### hw/rtl/sbas_checker.sv
// ============================================================================
// sbas_checker - port-level checks for the signed BCD adder
// Item delivery, sign of zero, flag consistency; bound to the top level.
// ============================================================================
module sbas_checker
    import sbas_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input t_in  i_in,
    input logic o_done,
    input t_out o_result
);

    // every accepted item comes out with o_done raised
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_done)
        else $error("item lost in pipeline");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 4))
        else $error("result without an item");

    a_no_neg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_result.sum_negative && (o_result.sum_digits == '0)))
        else $error("negative zero result");

    // overflow only when magnitudes were added
    a_ovf_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.overflow) |->
            $past(i_in.a_negative == (i_in.b_negative ^ i_in.op), 4))
        else $error("overflow on a subtraction");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_result.a_less_b && o_result.a_equal_b))
        else $error("less and equal both set");

endmodule

bind signed_bcd_add_subtract sbas_checker u_sbas_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_in     (i_in),
    .o_done   (o_done),
    .o_result (o_result)
);
